### hw/rtl/utf8_to_utf16_transcoder_top_assert.svh
// assertion macros shared by the transcoder modules
`ifndef UTF8_TO_UTF16_TRANSCODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define U2U_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// checked on every edge, reset included
`define U2U_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define U2U_ASSERT(name, clk, rst_n, prop)
`define U2U_ASSERT_NR(name, clk, prop)
`endif
`endif

### hw/rtl/u2u_pkg.sv
package u2u_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_UNIT  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MISSING   = 2'd1,
    ERR_BAD_TRAIL = 2'd2,
    ERR_BAD_LEAD  = 2'd3
  } err_e;

  // byte ranges
  localparam logic [7:0] AsciiMax      = 8'h7F;
  localparam logic [7:0] LeadTwoMin    = 8'hC2;
  localparam logic [7:0] LeadTwoMax    = 8'hDF;
  localparam logic [7:0] LeadThreeMin  = 8'hE0;
  localparam logic [7:0] LeadThreeMax  = 8'hEF;
  localparam logic [7:0] LeadFourMin   = 8'hF0;
  localparam logic [7:0] LeadFourMax   = 8'hF4;
  localparam logic [7:0] TrailMin      = 8'h80;
  localparam logic [7:0] TrailMax      = 8'hBF;
  localparam logic [7:0] TrailMinAfterE0 = 8'hA0;
  localparam logic [7:0] TrailMinAfterF0 = 8'h90;
  localparam logic [7:0] TrailMaxAfterF4 = 8'h8F;

  // utf-16 constants
  localparam logic [20:0] BmpMax     = 21'h00FFFF;
  localparam logic [19:0] SuppBase   = 20'h10000;
  localparam logic [15:0] SurrHiBase = 16'hD800;
  localparam logic [15:0] SurrLoBase = 16'hDC00;

  // result queue geometry
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] unit;
    logic [1:0]  error_code;
    logic        string_done;
    logic        run_last;
  } result_t;

  // results from one byte, up to two
  typedef struct packed {
    logic [1:0] count;
    result_t    res_a;
    result_t    res_b;
  } push_t;

endpackage

### hw/rtl/u2u_if.sv
// byte channel
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_mark;

  modport source (output valid, output in_byte, output end_mark, input ready);
  modport sink (input valid, input in_byte, input end_mark, output ready);
endinterface

// result channel
interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] unit;
  logic [1:0]  error_code;
  logic        string_done;
  logic        run_last;

  modport source (output valid, output kind, output unit, output error_code,
                  output string_done, output run_last, input ready);
  modport sink (input valid, input kind, input unit, input error_code,
                input string_done, input run_last, output ready);
endinterface

### hw/rtl/u2u_decode.sv
`include "utf8_to_utf16_transcoder_top_assert.svh"

module u2u_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  u2u_in_if.sink          in_i,
  input  logic            room_i,
  output u2u_pkg::push_t  push_o
);

  // input stage
  logic       stage_valid_q;
  logic [7:0] stage_byte_q;
  logic       stage_end_q;
  logic       consume;

  // sequence state
  logic [1:0]  bytes_left_q, bytes_left_d;
  logic [20:0] partial_point_q, partial_point_d;
  logic [7:0]  lead_value_q, lead_value_d;
  logic [1:0]  trail_position_q, trail_position_d;
  logic        bad_pending_q, bad_pending_d;
  logic        skipping_q, skipping_d;

  // decode temporaries
  u2u_pkg::push_t res;
  logic [7:0]  lo_bound;
  logic [7:0]  hi_bound;
  logic        t_bad;
  logic [20:0] t_point;
  logic [1:0]  t_left;
  logic [1:0]  need;
  logic [20:0] lead_bits;
  logic        lead_ok;

  function automatic u2u_pkg::result_t mk_res(input logic [1:0] kind,
                                              input logic [15:0] unit,
                                              input logic [1:0] code,
                                              input logic done,
                                              input logic last);
    u2u_pkg::result_t r;
    r.kind        = kind;
    r.unit        = unit;
    r.error_code  = code;
    r.string_done = done;
    r.run_last    = last;
    return r;
  endfunction

  function automatic u2u_pkg::push_t report(input logic [1:0] code, input logic endm);
    u2u_pkg::push_t p;
    p       = '0;
    p.count = 2'd1;
    p.res_a = mk_res(u2u_pkg::KIND_ERROR, 16'h0000, code, endm, 1'b1);
    return p;
  endfunction

  // single unit or surrogate pair
  function automatic u2u_pkg::push_t emit_point(input logic [20:0] cp, input logic endm);
    u2u_pkg::push_t p;
    logic [19:0] off;
    p   = '0;
    off = cp[19:0] - u2u_pkg::SuppBase;
    if (cp <= u2u_pkg::BmpMax) begin
      p.count = 2'd1;
      p.res_a = mk_res(u2u_pkg::KIND_UNIT, cp[15:0], u2u_pkg::ERR_NONE, endm, 1'b1);
    end else begin
      p.count = 2'd2;
      p.res_a = mk_res(u2u_pkg::KIND_UNIT, u2u_pkg::SurrHiBase + {6'b0, off[19:10]},
                       u2u_pkg::ERR_NONE, 1'b0, 1'b0);
      p.res_b = mk_res(u2u_pkg::KIND_UNIT, u2u_pkg::SurrLoBase + {6'b0, off[9:0]},
                       u2u_pkg::ERR_NONE, endm, 1'b1);
    end
    return p;
  endfunction

  // stage handshake
  assign consume    = stage_valid_q & room_i;
  assign in_i.ready = ~stage_valid_q | consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stage_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      stage_byte_q <= in_i.in_byte;
      stage_end_q  <= in_i.end_mark;
    end
  end

  // lead byte classes
  always_comb begin
    need      = 2'd0;
    lead_bits = '0;
    lead_ok   = 1'b0;
    if (stage_byte_q >= u2u_pkg::LeadTwoMin && stage_byte_q <= u2u_pkg::LeadTwoMax) begin
      need      = 2'd1;
      lead_bits = {16'b0, stage_byte_q[4:0]};
      lead_ok   = 1'b1;
    end else if (stage_byte_q >= u2u_pkg::LeadThreeMin &&
                 stage_byte_q <= u2u_pkg::LeadThreeMax) begin
      need      = 2'd2;
      lead_bits = {17'b0, stage_byte_q[3:0]};
      lead_ok   = 1'b1;
    end else if (stage_byte_q >= u2u_pkg::LeadFourMin &&
                 stage_byte_q <= u2u_pkg::LeadFourMax) begin
      need      = 2'd3;
      lead_bits = {18'b0, stage_byte_q[2:0]};
      lead_ok   = 1'b1;
    end
  end

  // trailing byte bounds and accumulation
  always_comb begin
    lo_bound = u2u_pkg::TrailMin;
    hi_bound = u2u_pkg::TrailMax;
    if (trail_position_q == 2'd0) begin
      if (lead_value_q == u2u_pkg::LeadThreeMin) begin
        lo_bound = u2u_pkg::TrailMinAfterE0;
      end else if (lead_value_q == u2u_pkg::LeadFourMin) begin
        lo_bound = u2u_pkg::TrailMinAfterF0;
      end else if (lead_value_q == u2u_pkg::LeadFourMax) begin
        hi_bound = u2u_pkg::TrailMaxAfterF4;
      end
    end
    t_bad   = bad_pending_q | (stage_byte_q < lo_bound) | (stage_byte_q > hi_bound);
    t_point = {partial_point_q[14:0], stage_byte_q[5:0]};
    t_left  = bytes_left_q - 2'd1;
  end

  // next state and results
  always_comb begin
    res              = '0;
    bytes_left_d     = bytes_left_q;
    partial_point_d  = partial_point_q;
    lead_value_d     = lead_value_q;
    trail_position_d = trail_position_q;
    bad_pending_d    = bad_pending_q;
    skipping_d       = skipping_q;
    if (skipping_q) begin
      if (stage_end_q) begin
        res.count  = 2'd1;
        res.res_a  = mk_res(u2u_pkg::KIND_END, 16'h0000, u2u_pkg::ERR_NONE, 1'b1, 1'b1);
        skipping_d = 1'b0;
      end
    end else begin
      // defaults for every path that closes a sequence
      bytes_left_d     = 2'd0;
      partial_point_d  = '0;
      lead_value_d     = '0;
      trail_position_d = 2'd0;
      bad_pending_d    = 1'b0;
      if (bytes_left_q == 2'd0) begin
        if (stage_byte_q <= u2u_pkg::AsciiMax) begin
          res = emit_point({13'b0, stage_byte_q}, stage_end_q);
        end else if (!lead_ok) begin
          res        = report(u2u_pkg::ERR_BAD_LEAD, stage_end_q);
          skipping_d = ~stage_end_q;
        end else if (stage_end_q) begin
          res = report(u2u_pkg::ERR_MISSING, stage_end_q);
        end else begin
          bytes_left_d    = need;
          partial_point_d = lead_bits;
          lead_value_d    = stage_byte_q;
        end
      end else if (t_left != 2'd0) begin
        if (stage_end_q) begin
          res = report(u2u_pkg::ERR_MISSING, stage_end_q);
        end else begin
          bytes_left_d     = t_left;
          partial_point_d  = t_point;
          lead_value_d     = lead_value_q;
          trail_position_d = trail_position_q + 2'd1;
          bad_pending_d    = t_bad;
        end
      end else if (t_bad) begin
        res        = report(u2u_pkg::ERR_BAD_TRAIL, stage_end_q);
        skipping_d = ~stage_end_q;
      end else begin
        res = emit_point(t_point, stage_end_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q     <= 2'd0;
      partial_point_q  <= '0;
      lead_value_q     <= '0;
      trail_position_q <= 2'd0;
      bad_pending_q    <= 1'b0;
      skipping_q       <= 1'b0;
    end else if (consume) begin
      bytes_left_q     <= bytes_left_d;
      partial_point_q  <= partial_point_d;
      lead_value_q     <= lead_value_d;
      trail_position_q <= trail_position_d;
      bad_pending_q    <= bad_pending_d;
      skipping_q       <= skipping_d;
    end
  end

  // results go to the queue only when a byte is consumed
  always_comb begin
    push_o = res;
    if (!consume) begin
      push_o.count = 2'd0;
    end
  end

  `U2U_ASSERT(a_skip_no_seq, clk_i, rst_ni, skipping_q |-> (bytes_left_q == 2'd0))
  `U2U_ASSERT(a_idle_clean, clk_i, rst_ni,
              (bytes_left_q == 2'd0) |-> (trail_position_q == 2'd0 && !bad_pending_q))
  `U2U_ASSERT(a_pair_units, clk_i, rst_ni,
              (push_o.count == 2'd2) |-> (push_o.res_a.kind == u2u_pkg::KIND_UNIT &&
                                          push_o.res_b.kind == u2u_pkg::KIND_UNIT &&
                                          !push_o.res_a.run_last))

endmodule

### hw/rtl/u2u_outq.sv
`include "utf8_to_utf16_transcoder_top_assert.svh"

module u2u_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u2u_pkg::push_t  push_i,
  output logic            room_o,
  u2u_out_if.source       out_o
);

  localparam logic [u2u_pkg::QCntW-1:0] DepthCnt = u2u_pkg::QCntW'(u2u_pkg::QDepth);
  localparam logic [u2u_pkg::QCntW-1:0] RoomMax  = u2u_pkg::QCntW'(u2u_pkg::QDepth - 2);

  u2u_pkg::result_t mem_q [u2u_pkg::QDepth];
  logic [u2u_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [u2u_pkg::QCntW-1:0] count_q, count_after_pop;
  logic [u2u_pkg::QPtrW-1:0] wr_next;
  logic                      pop;
  u2u_pkg::result_t          head;

  // pop side
  assign pop             = out_o.valid & out_o.ready;
  assign count_after_pop = count_q - u2u_pkg::QCntW'(pop);
  assign room_o          = count_after_pop <= RoomMax;
  assign wr_next         = wr_ptr_q + u2u_pkg::QPtrW'(1);

  // entry writes
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res_a;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.res_b;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + u2u_pkg::QPtrW'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + u2u_pkg::QPtrW'(1);
      end
      count_q <= count_after_pop + u2u_pkg::QCntW'(push_i.count);
    end
  end

  // head of queue drives the result channel
  assign head              = mem_q[rd_ptr_q];
  assign out_o.valid       = count_q != '0;
  assign out_o.kind        = head.kind;
  assign out_o.unit        = head.unit;
  assign out_o.error_code  = head.error_code;
  assign out_o.string_done = head.string_done;
  assign out_o.run_last    = head.run_last;

  `U2U_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= DepthCnt)
  `U2U_ASSERT(a_push_has_room, clk_i, rst_ni, (push_i.count != 2'd0) |-> room_o)
  `U2U_ASSERT(a_push_shows, clk_i, rst_ni,
              (count_q == '0 && push_i.count != 2'd0) |=> out_o.valid)

endmodule

### hw/rtl/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16 transcoder
// in_i carries one UTF-8 byte per item, with end_mark set on the last byte of
// a string. out_o carries result items: a UTF-16 code unit, an error report,
// or a bare end-of-string mark; string_done flags the final result of the
// end-marked byte and run_last the last result caused by each byte.
// Encoded surrogates pass through; code points above the BMP come out as a
// high then low surrogate, two result items for one byte.
// An accepted byte is registered in the input stage, then its results are
// written to the result queue, which drives out_o.
// Throughput: one byte per cycle while the queue has room; a byte closing a
// four-byte sequence gives two results, absorbed by the four-entry queue.
// in_i.ready drops only while the queue cannot take two more results.
// Reset clears the decode state and empties the queue; no clearing pass.
// When the receiver stalls, results wait in the queue and the input stage
// holds its byte until room opens up.
module utf8_to_utf16_transcoder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  u2u_in_if.sink    in_i,
  u2u_out_if.source out_o
);

  u2u_pkg::push_t push;
  logic           room;

  // byte decode and sequence state
  u2u_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  // result queue
  u2u_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
